[src/plls_pkg.sv]
package plls_pkg;

  // field widths
  localparam int unsigned AngleW  = 16;
  localparam int unsigned SpeedW  = 25;
  localparam int unsigned PropW   = 16;
  localparam int unsigned IntegW  = 24;
  localparam int unsigned LimitW  = 24;
  localparam int unsigned PeriodW = 24;

  // shared multiplier: signed 25 x (unsigned 24 extended to signed 25)
  localparam int unsigned MulAW = 25;
  localparam int unsigned MulBW = 25;
  localparam int unsigned MulPW = MulAW + MulBW;

  // apb
  localparam int unsigned AddrW = 4;
  localparam int unsigned DataW = 32;

  // register reset values
  localparam logic [PropW-1:0]   PropGainRst     = 16'd25600;
  localparam logic [IntegW-1:0]  IntegGainRst    = 24'd6554;
  localparam logic [LimitW-1:0]  SpeedLimitRst   = 24'd9830400;
  localparam logic [PeriodW-1:0] SamplePeriodRst = 24'd33554;

  // register indexes (paddr[3:2])
  typedef enum logic [1:0] {
    REG_PROP_GAIN     = 2'd0,
    REG_INTEG_GAIN    = 2'd1,
    REG_SPEED_LIMIT   = 2'd2,
    REG_SAMPLE_PERIOD = 2'd3
  } reg_idx_e;

  // request to the shared multiplier
  typedef struct packed {
    logic                    en;
    logic signed [MulAW-1:0] a;
    logic signed [MulBW-1:0] b;
  } mul_req_t;

endpackage

[src/plls_ifs.sv]
interface plls_sample_if;
  import plls_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [AngleW-1:0] measured_angle;
  logic                     restart;

  modport source (output valid, output measured_angle, output restart, input ready);
  modport sink   (input valid, input measured_angle, input restart, output ready);
endinterface

interface plls_result_if;
  import plls_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [SpeedW-1:0] speed_estimate;
  logic signed [AngleW-1:0] angle_estimate;

  modport source (output valid, output speed_estimate, output angle_estimate, input ready);
  modport sink   (input valid, input speed_estimate, input angle_estimate, output ready);
endinterface

[src/plls_mul.sv]
module plls_mul (
  input  logic                                   clk_i,
  input  plls_pkg::mul_req_t                     req_i,
  output logic signed [plls_pkg::MulPW-1:0]      prod_o
);
  import plls_pkg::*;

  logic signed [MulPW-1:0] prod_q;

  // registered product, held while idle
  always_ff @(posedge clk_i) begin
    if (req_i.en) begin
      prod_q <= MulPW'(req_i.a) * MulPW'(req_i.b);
    end
  end

  assign prod_o = prod_q;
endmodule

[src/pll_angle_speed_observer_top.sv]
// channel   dir  handshake      payload
// sample_i  in   valid/ready    measured_angle[15:0] signed, restart
// result_o  out  valid/ready    speed_estimate[24:0] signed Q8.16, angle_estimate[15:0]
// apb       in   psel/penable   paddr[3:0], pwdata[31:0], prdata[31:0], pready tied high
//
// a sample steps through mul_p, mul_i, acc, speed, mul_s and angle before done loads the
// result register; a restart goes straight to done; ready returns with that load
// the state sequence is set by three dependent products through one shared multiplier
// rst_ni clears config to defaults, state to zero and the result register
// sample ready is high only while idle; a finished result waits in the output
// register, so the next sample runs while the old result is still not taken
module pll_angle_speed_observer_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  plls_sample_if.sink                       sample_i,
  plls_result_if.source                     result_o,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [plls_pkg::AddrW-1:0]        paddr,
  input  logic [plls_pkg::DataW-1:0]        pwdata,
  output logic [plls_pkg::DataW-1:0]        prdata,
  output logic                              pready
);
  import plls_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_P,
    ST_MUL_I,
    ST_ACC,
    ST_SPEED,
    ST_MUL_S,
    ST_ANGLE,
    ST_DONE
  } state_e;

  // configuration registers
  logic [PropW-1:0]   prop_gain_q;
  logic [IntegW-1:0]  integ_gain_q;
  logic [LimitW-1:0]  speed_limit_q;
  logic [PeriodW-1:0] sample_period_q;

  // observer state and work registers
  state_e                   state_q;
  logic [AngleW-1:0]        est_angle_q;
  logic signed [SpeedW-1:0] integ_acc_q;
  logic signed [AngleW-1:0] err_q;
  logic signed [SpeedW-1:0] up_q;
  logic signed [SpeedW-1:0] speed_q;

  // result register
  logic                     out_valid_q;
  logic signed [SpeedW-1:0] out_speed_q;
  logic signed [AngleW-1:0] out_angle_q;
  logic                     out_load;

  mul_req_t                mul_req;
  logic signed [MulPW-1:0] prod;

  logic                    in_xfer;
  logic                    cfg_wr;
  reg_idx_e                cfg_idx;

  // rounding shifts: add half an lsb, then arithmetic shift (ties toward +inf)
  logic signed [MulPW-1:0]  rnd_p;
  logic signed [MulPW-1:0]  rnd_i;
  logic signed [MulPW-1:0]  rnd_s;
  logic signed [SpeedW:0]   acc_sum;
  logic signed [SpeedW:0]   spd_sum;
  logic signed [SpeedW:0]   lim_pos;
  logic signed [SpeedW:0]   lim_neg;
  logic signed [SpeedW-1:0] acc_clamped;
  logic signed [SpeedW-1:0] spd_clamped;
  logic [AngleW-1:0]        step;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign cfg_idx = reg_idx_e'(paddr[3:2]);

  assign sample_i.ready = (state_q == ST_IDLE);
  assign in_xfer        = sample_i.valid & sample_i.ready;

  // finished estimate moves into the output register once it is free
  assign out_load = (state_q == ST_DONE) && (!out_valid_q || result_o.ready);

  assign result_o.valid          = out_valid_q;
  assign result_o.speed_estimate = out_speed_q;
  assign result_o.angle_estimate = out_angle_q;

  // register read back
  always_comb begin
    case (cfg_idx)
      REG_PROP_GAIN:     prdata = DataW'(prop_gain_q);
      REG_INTEG_GAIN:    prdata = DataW'(integ_gain_q);
      REG_SPEED_LIMIT:   prdata = DataW'(speed_limit_q);
      REG_SAMPLE_PERIOD: prdata = DataW'(sample_period_q);
      default:           prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prop_gain_q     <= PropGainRst;
      integ_gain_q    <= IntegGainRst;
      speed_limit_q   <= SpeedLimitRst;
      sample_period_q <= SamplePeriodRst;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_PROP_GAIN:     prop_gain_q     <= pwdata[PropW-1:0];
        REG_INTEG_GAIN:    integ_gain_q    <= pwdata[IntegW-1:0];
        REG_SPEED_LIMIT:   speed_limit_q   <= pwdata[LimitW-1:0];
        REG_SAMPLE_PERIOD: sample_period_q <= pwdata[PeriodW-1:0];
        default: ;
      endcase
    end
  end

  // operand select for the shared multiplier
  always_comb begin
    mul_req = '0;
    case (state_q)
      ST_MUL_P: begin
        mul_req.en = 1'b1;
        mul_req.a  = MulAW'(err_q);
        mul_req.b  = $signed(MulBW'(prop_gain_q));
      end
      ST_MUL_I: begin
        mul_req.en = 1'b1;
        mul_req.a  = MulAW'(err_q);
        mul_req.b  = $signed(MulBW'(integ_gain_q));
      end
      ST_MUL_S: begin
        mul_req.en = 1'b1;
        mul_req.a  = MulAW'(speed_q);
        mul_req.b  = $signed(MulBW'(sample_period_q));
      end
      default: mul_req = '0;
    endcase
  end

  plls_mul u_mul (
    .clk_i  (clk_i),
    .req_i  (mul_req),
    .prod_o (prod)
  );

  always_comb begin
    rnd_p   = prod + (MulPW'(1) <<< 7);
    rnd_i   = prod + (MulPW'(1) <<< 15);
    rnd_s   = prod + (MulPW'(1) <<< 23);
    lim_pos = $signed({2'b00, speed_limit_q});
    lim_neg = -lim_pos;

    // integral update, clamped to the limit
    acc_sum = (SpeedW+1)'(integ_acc_q) + (SpeedW+1)'($signed(rnd_i[SpeedW+15:16]));
    if (acc_sum > lim_pos) begin
      acc_clamped = lim_pos[SpeedW-1:0];
    end else if (acc_sum < lim_neg) begin
      acc_clamped = lim_neg[SpeedW-1:0];
    end else begin
      acc_clamped = acc_sum[SpeedW-1:0];
    end

    // p term plus integral, clamped to the limit
    spd_sum = (SpeedW+1)'(up_q) + (SpeedW+1)'(integ_acc_q);
    if (spd_sum > lim_pos) begin
      spd_clamped = lim_pos[SpeedW-1:0];
    end else if (spd_sum < lim_neg) begin
      spd_clamped = lim_neg[SpeedW-1:0];
    end else begin
      spd_clamped = spd_sum[SpeedW-1:0];
    end

    // angle advance, kept modulo one turn
    step = rnd_s[AngleW+23:24];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      est_angle_q <= '0;
      integ_acc_q <= '0;
      out_valid_q <= 1'b0;
      err_q       <= '0;
      up_q        <= '0;
      speed_q     <= '0;
      out_speed_q <= '0;
      out_angle_q <= '0;
    end else begin
      // result register: load a finished estimate, else drop the one taken
      if (out_load) begin
        out_valid_q <= 1'b1;
        out_speed_q <= speed_q;
        out_angle_q <= $signed(est_angle_q);
      end else if (out_valid_q && result_o.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_xfer) begin
            if (sample_i.restart) begin
              est_angle_q <= '0;
              integ_acc_q <= '0;
              speed_q     <= '0;
              state_q     <= ST_DONE;
            end else begin
              // phase error wraps into one turn
              err_q   <= $signed(sample_i.measured_angle - est_angle_q);
              state_q <= ST_MUL_P;
            end
          end
        end
        ST_MUL_P: state_q <= ST_MUL_I;
        ST_MUL_I: begin
          up_q    <= rnd_p[SpeedW+7:8];
          state_q <= ST_ACC;
        end
        ST_ACC: begin
          integ_acc_q <= acc_clamped;
          state_q     <= ST_SPEED;
        end
        ST_SPEED: begin
          speed_q <= spd_clamped;
          state_q <= ST_MUL_S;
        end
        ST_MUL_S: state_q <= ST_ANGLE;
        ST_ANGLE: begin
          est_angle_q <= est_angle_q + step;
          state_q     <= ST_DONE;
        end
        ST_DONE: begin
          // wait here until the output register takes the result
          if (out_load) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end
endmodule

[src/plls_checker.sv]
module plls_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_valid_i,
  input logic                              in_ready_i,
  input logic                              in_restart_i,
  input logic                              out_valid_i,
  input logic                              out_ready_i,
  input logic signed [plls_pkg::SpeedW-1:0] out_speed_i,
  input logic signed [plls_pkg::AngleW-1:0] out_angle_i
);
  import plls_pkg::*;

  // one sample at a time: not ready right after a transfer
  a_busy_after_xfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("sample taken while busy");

  // a restart into an empty output register gives a zero result, through ST_DONE into the output register
  a_restart_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && in_restart_i && !out_valid_i
    |=> ##1 (out_valid_i && out_speed_i == '0 && out_angle_i == '0))
    else $error("restart result not zero");

  // a stalled result stays
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_speed_i)
    && $stable(out_angle_i))
    else $error("stalled result changed");
endmodule

bind pll_angle_speed_observer_top plls_checker u_plls_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (sample_i.valid),
  .in_ready_i   (sample_i.ready),
  .in_restart_i (sample_i.restart),
  .out_valid_i  (result_o.valid),
  .out_ready_i  (result_o.ready),
  .out_speed_i  (result_o.speed_estimate),
  .out_angle_i  (result_o.angle_estimate)
);

[tb/plls_observer_checker.sv]
`timescale 1ns / 100ps

module plls_observer_checker
  import plls_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  plls_sample_if             sample_if,
  plls_result_if             result_if,
  input  logic               psel_i,
  input  logic               penable_i,
  input  logic               pwrite_i,
  input  logic               pready_i,
  input  logic [AddrW-1:0]   paddr_i,
  input  logic [DataW-1:0]   pwdata_i,
  output int unsigned        mismatches_o,
  output int unsigned        outstanding_o
);

  typedef struct packed {
    logic signed [SpeedW-1:0] speed;
    logic signed [AngleW-1:0] angle;
  } estimate_t;

  // mirrored registers and observer state
  logic [PropW-1:0]   prop_gain_q;
  logic [IntegW-1:0]  integ_gain_q;
  logic [LimitW-1:0]  speed_limit_q;
  logic [PeriodW-1:0] sample_period_q;
  logic [AngleW-1:0]  angle_q;
  longint             integ_q;

  estimate_t   estimates_q[$];
  int unsigned mismatch_count = 0;
  int unsigned outstanding    = 0;

  assign mismatches_o  = mismatch_count;
  assign outstanding_o = outstanding;

  // rescale with round to nearest, ties toward +inf
  function automatic longint round_shift(longint x, int unsigned s);
    return (x + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic longint clamp_sym(longint x, longint lim);
    if (x > lim) return lim;
    if (x < -lim) return -lim;
    return x;
  endfunction

  task automatic flag_mismatch(string what, longint want, longint got);
    mismatch_count++;
    $display("%0t: %s mismatch, expected %0d actual %0d", $time, what, want, got);
  endtask

  task automatic track_sample(logic signed [AngleW-1:0] meas, logic restart);
    logic signed [AngleW-1:0] err;
    longint p_term, acc, speed, adv;
    estimate_t est;
    if (restart) begin
      angle_q = '0;
      integ_q = 0;
      est     = '0;
    end else begin
      // phase error wraps into one turn
      err    = meas - angle_q;
      p_term = round_shift(longint'(err) * longint'(prop_gain_q), 8);
      acc    = integ_q + round_shift(longint'(err) * longint'(integ_gain_q), 16);
      acc    = clamp_sym(acc, longint'(speed_limit_q));
      integ_q = acc;
      speed  = clamp_sym(p_term + acc, longint'(speed_limit_q));
      // Q8.16 Hz times Q0.24 s gives 1/65536 turn
      adv     = round_shift(speed * longint'(sample_period_q), 24);
      angle_q = angle_q + adv[AngleW-1:0];
      est.speed = speed[SpeedW-1:0];
      est.angle = angle_q;
    end
    estimates_q.push_back(est);
  endtask

  task automatic check_result(logic signed [SpeedW-1:0] speed, logic signed [AngleW-1:0] angle);
    estimate_t est;
    if (estimates_q.size() == 0) begin
      flag_mismatch("unrequested result speed", 0, speed);
      return;
    end
    est = estimates_q.pop_front();
    if (speed !== est.speed) flag_mismatch("speed_estimate", est.speed, speed);
    if (angle !== est.angle) flag_mismatch("angle_estimate", est.angle, angle);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prop_gain_q     = PropGainRst;
      integ_gain_q    = IntegGainRst;
      speed_limit_q   = SpeedLimitRst;
      sample_period_q = SamplePeriodRst;
      angle_q         = '0;
      integ_q         = 0;
      estimates_q.delete();
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (reg_idx_e'(paddr_i[3:2]))
          REG_PROP_GAIN:     prop_gain_q     = pwdata_i[PropW-1:0];
          REG_INTEG_GAIN:    integ_gain_q    = pwdata_i[IntegW-1:0];
          REG_SPEED_LIMIT:   speed_limit_q   = pwdata_i[LimitW-1:0];
          REG_SAMPLE_PERIOD: sample_period_q = pwdata_i[PeriodW-1:0];
          default: ;
        endcase
      end
      if (sample_if.valid && sample_if.ready) begin
        track_sample(sample_if.measured_angle, sample_if.restart);
      end
      if (result_if.valid && result_if.ready) begin
        check_result(result_if.speed_estimate, result_if.angle_estimate);
      end
    end
    outstanding = estimates_q.size();
  end

endmodule

[tb/pll_angle_speed_observer_top_tb.sv]
`timescale 1ns / 100ps

module pll_angle_speed_observer_top_tb;
  import plls_pkg::*;

  // cycles without any transfer before the run is declared hung; the worst
  // correct case is the long receiver hold of HoldCycles
  localparam int unsigned StallLimit = 4000;
  localparam int unsigned HoldCycles = 400;

  typedef enum int unsigned {
    READY_ALWAYS,
    READY_RANDOM,
    READY_PATTERN
  } ready_mode_e;

  logic clk_i;
  logic rst_ni;

  plls_sample_if sample_if ();
  plls_result_if result_if ();

  // apb
  logic             psel;
  logic             penable;
  logic             pwrite;
  logic [AddrW-1:0] paddr;
  logic [DataW-1:0] pwdata;
  logic [DataW-1:0] prdata;
  logic             pready;

  int unsigned mismatches;
  int unsigned outstanding;

  // stimulus bookkeeping
  int unsigned burst_left = 0;
  bit          no_gaps    = 1'b0;
  bit          hold_req   = 1'b0;
  bit          hold_done  = 1'b0;
  logic [AngleW-1:0] rotor = '0;
  int unsigned stall_cycles = 0;

  pll_angle_speed_observer_top u_top (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .sample_i (sample_if),
    .result_o (result_if),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // prediction and comparison live in the checker
  plls_observer_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .sample_if     (sample_if),
    .result_if     (result_if),
    .psel_i        (psel),
    .penable_i     (penable),
    .pwrite_i      (pwrite),
    .pready_i      (pready),
    .paddr_i       (paddr),
    .pwdata_i      (pwdata),
    .mismatches_o  (mismatches),
    .outstanding_o (outstanding)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // one apb write: setup cycle then access cycle; the select stays up so that
  // back-to-back writes need no second assignment in one step
  task automatic write_reg(input reg_idx_e idx, input logic [DataW-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
  endtask

  // full register set; upper bits beyond a register's width are dropped by the block
  task automatic configure(input logic [DataW-1:0] kp, input logic [DataW-1:0] ki,
                           input logic [DataW-1:0] lim, input logic [DataW-1:0] per);
    write_reg(REG_PROP_GAIN, kp);
    write_reg(REG_INTEG_GAIN, ki);
    write_reg(REG_SPEED_LIMIT, lim);
    write_reg(REG_SAMPLE_PERIOD, per);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // offer one sample and wait for its transfer; bursts of random length with
  // random gaps in between
  task automatic offer(input logic signed [AngleW-1:0] ang, input logic rs);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0 || no_gaps) ? 0 : $urandom_range(1, 9);
      burst_left = $urandom_range(1, 12);
      if (gap != 0) begin
        sample_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    sample_if.valid          <= 1'b1;
    sample_if.measured_angle <= ang;
    sample_if.restart        <= rs;
    @(posedge clk_i);
    while (!sample_if.ready) @(posedge clk_i);
  endtask

  // stop sending, wait until every estimate has been taken, then let the
  // block settle before any register write
  task automatic drain();
    sample_if.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
  endtask

  task automatic run_random(input int unsigned n_items);
    int unsigned sent, len, pick;
    int rate;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        // rotor turning at a steady rate with jitter, so the loop can lock
        len  = $urandom_range(8, 40);
        rate = int'($urandom_range(0, 4000)) - 2000;
        if ($urandom_range(0, 2) == 0) begin
          offer(rotor, 1'b1);
          sent++;
        end
        repeat (len) begin
          rotor = rotor + AngleW'(rate);
          offer(AngleW'(int'(rotor) + int'($urandom_range(0, 64)) - 32), 1'b0);
          sent++;
        end
      end else if (pick < 88) begin
        // unrelated angles over the whole range
        repeat ($urandom_range(1, 6)) begin
          offer(AngleW'($urandom()), 1'b0);
          sent++;
        end
      end else if (pick < 94) begin
        // phase jump of half a turn, breaks the running sequence
        rotor = rotor + 16'h8000;
      end else begin
        // restart at an arbitrary point with a random angle field
        offer(AngleW'($urandom()), 1'b1);
        sent++;
      end
    end
  endtask

  // receiver: ready follows changing patterns, plus one long hold so that the
  // output register fills and the sample input backs up
  initial begin
    ready_mode_e mode;
    int unsigned span;
    result_if.ready = 1'b0;
    wait (rst_ni);
    forever begin
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        result_if.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
      end
      mode = ready_mode_e'($urandom_range(0, 2));
      span = $urandom_range(10, 60);
      for (int unsigned i = 0; i < span; i++) begin
        case (mode)
          READY_ALWAYS: result_if.ready <= 1'b1;
          READY_RANDOM: result_if.ready <= 1'($urandom_range(0, 1));
          default:      result_if.ready <= (i % 3 == 0);
        endcase
        @(posedge clk_i);
      end
    end
  end

  // watchdog on cycles with no transfer on either channel
  always @(posedge clk_i) begin
    if (!rst_ni || (sample_if.valid && sample_if.ready) ||
        (result_if.valid && result_if.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= StallLimit) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  initial begin
    sample_if.valid          = 1'b0;
    sample_if.measured_angle = '0;
    sample_if.restart        = 1'b0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    rst_ni  = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed samples at reset settings
    offer(16'sd0, 1'b0);
    offer(16'sd32767, 1'b0);
    offer(-16'sd32768, 1'b0);
    offer(16'sd0, 1'b1);
    // half-turn error from a zero estimate stays minus half a turn
    offer(-16'sd32768, 1'b0);
    // restart with a nonzero angle field still yields zeros
    offer(16'sd32767, 1'b1);
    offer(16'sd1, 1'b0);
    offer(-16'sd1, 1'b0);
    offer(16'sd16384, 1'b0);
    offer(-16'sd16384, 1'b0);
    offer(-16'sd32768, 1'b1);
    // constant target to pull the loop in
    repeat (8) offer(16'sd1000, 1'b0);
    offer(-16'sd32768, 1'b0);
    offer(16'sd12345, 1'b0);
    drain();

    // every register at its maximum, extra upper bits set
    configure(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    run_random(105);
    drain();

    // zero speed limit pins integral and speed to zero
    configure(32'd25600, 32'd6554, 32'd0, 32'd33554);
    run_random(105);
    drain();

    // zero sample period: speed moves, angle estimate stays put
    configure(32'd25600, 32'd6554, 32'd9830400, 32'd0);
    run_random(105);
    drain();

    // smallest nonzero gains and period, widest limit
    configure(32'd1, 32'd1, 32'hFF_FFFF, 32'd1);
    run_random(105);
    drain();

    // default values written back, with the long receiver hold
    hold_req = 1'b1;
    configure(32'd25600, 32'd6554, 32'd9830400, 32'd33554);
    run_random(105);
    drain();

    // random settings, sender with no gaps
    no_gaps = 1'b1;
    configure($urandom(), $urandom(), $urandom(), $urandom_range(1, 32'hFF_FFFF));
    run_random(105);
    drain();
    no_gaps = 1'b0;

    configure($urandom_range(0, 32'hFFFF), $urandom_range(0, 32'hFF_FFFF),
              $urandom_range(0, 32'hFF_FFFF), $urandom_range(1, 32'hFF_FFFF));
    run_random(105);
    drain();

    if (mismatches == 0 && outstanding == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

[filelist.f]
src/plls_pkg.sv
src/plls_ifs.sv
src/plls_mul.sv
src/pll_angle_speed_observer_top.sv
src/plls_checker.sv
tb/plls_observer_checker.sv
tb/pll_angle_speed_observer_top_tb.sv
